// ----- rtl/mwm_pkg.sv -----
// mecanum wheel mixer package: widths, pipeline stage map, shared types
// and the clamp and saturate helpers used by the mixer stages
// no dependencies
package mwm_pkg;

   // field widths
   localparam int SPEED_WIDTH = 16;
   localparam int REG_WIDTH   = 15;
   localparam int SUM_WIDTH   = SPEED_WIDTH + 2;
   localparam int MAG_WIDTH   = SPEED_WIDTH + 1;
   localparam int PROD_WIDTH  = MAG_WIDTH + REG_WIDTH;
   localparam int CMP_WIDTH   = ((SPEED_WIDTH > REG_WIDTH) ? SPEED_WIDTH : REG_WIDTH) + 1;
   localparam int WIDE_WIDTH  = (MAG_WIDTH > REG_WIDTH) ? MAG_WIDTH : REG_WIDTH;
   localparam int NUM_WHEELS  = 4;

   // divider: one quotient bit per step, three steps per stage
   localparam int DIV_STEPS_PER_STAGE = 3;
   localparam int DIV_STAGES =
      (REG_WIDTH + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

   // pipeline stage map
   localparam int ST_CLAMP   = 0;
   localparam int ST_SUM     = 1;
   localparam int ST_MAX     = 2;
   localparam int ST_MUL     = 3;
   localparam int ST_DIV     = 4;
   localparam int ST_OUT     = ST_DIV + DIV_STAGES;
   localparam int NUM_STAGES = ST_OUT + 1;

   localparam int CSR_INDEX_WIDTH = 2;

   typedef logic signed [SPEED_WIDTH-1:0] speed_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic [REG_WIDTH-1:0]          reg_type;
   typedef logic [MAG_WIDTH-1:0]          mag_type;

   // register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LIMIT_FORWARD  = 2'd0,
      CSR_LIMIT_SIDEWAYS = 2'd1,
      CSR_LIMIT_ROTATION = 2'd2,
      CSR_WHEEL_LIMIT    = 2'd3
   } csr_index_type;

   typedef struct packed {
      reg_type limit_forward;
      reg_type limit_sideways;
      reg_type limit_rotation;
      reg_type wheel_limit;
   } cfg_type;

   // one wheel's unscaled speed as it enters the scaling lane
   typedef struct packed {
      mag_type   mag;
      logic      neg;
      speed_type sat;
   } lane_cmd_type;

   typedef struct packed {
      speed_type speed;
      logic      scaled;
   } lane_out_type;

   // per-stage load enables from the handshake control
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } load_type;

   // symmetric clamp of a command to [-lim, +lim]
   function automatic speed_type clamp_sym(input speed_type v, input reg_type lim);
      logic signed [CMP_WIDTH-1:0] ve;
      logic signed [CMP_WIDTH-1:0] le;
      ve = CMP_WIDTH'(v);
      le = $signed(CMP_WIDTH'(lim));
      if (ve > le) begin
         return SPEED_WIDTH'(le);
      end else if (ve < -le) begin
         return SPEED_WIDTH'(-le);
      end
      return v;
   endfunction

   // saturate a wheel sum to the speed range
   function automatic speed_type sat_speed(input sum_type t);
      sum_type hi;
      sum_type lo;
      hi = {{(SUM_WIDTH-SPEED_WIDTH+1){1'b0}}, {(SPEED_WIDTH-1){1'b1}}};
      lo = ~hi;
      if (t > hi) begin
         return SPEED_WIDTH'(hi);
      end else if (t < lo) begin
         return SPEED_WIDTH'(lo);
      end
      return SPEED_WIDTH'(t);
   endfunction

endpackage

// ----- rtl/mwm_req_if.sv -----
// command channel of the mecanum wheel mixer: valid, ready and three speeds
// depends on mwm_pkg
interface mwm_req_if import mwm_pkg::*; ();

   logic      valid;
   logic      ready;
   speed_type speed_forward;
   speed_type speed_sideways;
   speed_type speed_rotation;

   modport source (
      output valid,
      output speed_forward,
      output speed_sideways,
      output speed_rotation,
      input  ready
   );

   modport sink (
      input  valid,
      input  speed_forward,
      input  speed_sideways,
      input  speed_rotation,
      output ready
   );

endinterface

// ----- rtl/mwm_rsp_if.sv -----
// result channel of the mecanum wheel mixer: valid, ready, four wheel speeds
// and the scaling flag; depends on mwm_pkg
interface mwm_rsp_if import mwm_pkg::*; ();

   logic      valid;
   logic      ready;
   speed_type wheel0_speed;
   speed_type wheel1_speed;
   speed_type wheel2_speed;
   speed_type wheel3_speed;
   logic      was_scaled;

   modport source (
      output valid,
      output wheel0_speed,
      output wheel1_speed,
      output wheel2_speed,
      output wheel3_speed,
      output was_scaled,
      input  ready
   );

   modport sink (
      input  valid,
      input  wheel0_speed,
      input  wheel1_speed,
      input  wheel2_speed,
      input  wheel3_speed,
      input  was_scaled,
      output ready
   );

endinterface

// ----- rtl/mwm_csr.sv -----
// configuration registers of the mecanum wheel mixer: three command limits
// and the wheel limit; depends on mwm_pkg
module mwm_csr import mwm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  reg_type                    csr_write_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LIMIT_FORWARD:  cfg_in.limit_forward  = csr_write_data;
            CSR_LIMIT_SIDEWAYS: cfg_in.limit_sideways = csr_write_data;
            CSR_LIMIT_ROTATION: cfg_in.limit_rotation = csr_write_data;
            CSR_WHEEL_LIMIT:    cfg_in.wheel_limit    = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit_forward  <= REG_WIDTH'(8000);
         cfg_ff.limit_sideways <= REG_WIDTH'(8000);
         cfg_ff.limit_rotation <= REG_WIDTH'(8000);
         cfg_ff.wheel_limit    <= REG_WIDTH'(3500);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/mwm_mix.sv -----
// front stages of the mixer: command clamp, wheel sums with magnitudes,
// largest magnitude and the scaling decision; depends on mwm_pkg
module mwm_mix import mwm_pkg::*; (
   input  logic                            clock,
   input  load_type                        ctrl,
   input  cfg_type                         cfg,
   input  speed_type                       speed_forward,
   input  speed_type                       speed_sideways,
   input  speed_type                       speed_rotation,
   output lane_cmd_type [NUM_WHEELS-1:0]   cmd,
   output mag_type                         max_mag,
   output logic                            scaled
);

   speed_type x_ff, y_ff, w_ff;
   speed_type x_in, y_in, w_in;

   lane_cmd_type [NUM_WHEELS-1:0] sum_ff;
   lane_cmd_type [NUM_WHEELS-1:0] sum_in;

   lane_cmd_type [NUM_WHEELS-1:0] cmd_ff;
   mag_type                       max_ff;
   mag_type                       max_in;
   logic                          scaled_ff;
   logic                          scaled_in;

   sum_type                       xe, ye, we;
   sum_type [NUM_WHEELS-1:0]      t;
   mag_type                       max01, max23;

   // clamp stage
   always_comb begin
      x_in = clamp_sym(speed_forward,  cfg.limit_forward);
      y_in = clamp_sym(speed_sideways, cfg.limit_sideways);
      w_in = clamp_sym(speed_rotation, cfg.limit_rotation);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_CLAMP]) begin
         x_ff <= x_in;
         y_ff <= y_in;
         w_ff <= w_in;
      end
   end

   // wheel sums, magnitude, sign and saturated value
   always_comb begin
      xe   = SUM_WIDTH'(x_ff);
      ye   = SUM_WIDTH'(y_ff);
      we   = SUM_WIDTH'(w_ff);
      t[0] =  xe - ye + we;
      t[1] = -xe - ye + we;
      t[2] = -xe + ye + we;
      t[3] =  xe + ye + we;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         sum_in[i].neg = t[i][SUM_WIDTH-1];
         sum_in[i].mag = t[i][SUM_WIDTH-1] ? MAG_WIDTH'(-t[i]) : MAG_WIDTH'(t[i]);
         sum_in[i].sat = sat_speed(t[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_SUM]) begin
         sum_ff <= sum_in;
      end
   end

   // largest magnitude over the four wheels, compare with the wheel limit
   always_comb begin
      max01     = (sum_ff[1].mag > sum_ff[0].mag) ? sum_ff[1].mag : sum_ff[0].mag;
      max23     = (sum_ff[3].mag > sum_ff[2].mag) ? sum_ff[3].mag : sum_ff[2].mag;
      max_in    = (max23 > max01) ? max23 : max01;
      scaled_in = WIDE_WIDTH'(max_in) > WIDE_WIDTH'(cfg.wheel_limit);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_MAX]) begin
         cmd_ff    <= sum_ff;
         max_ff    <= max_in;
         scaled_ff <= scaled_in;
      end
   end

   assign cmd     = cmd_ff;
   assign max_mag = max_ff;
   assign scaled  = scaled_ff;

endmodule

// ----- rtl/mwm_lane.sv -----
// one wheel's scaling lane: product with the wheel limit, pipelined
// restoring divide by the largest magnitude, final select; depends on mwm_pkg
module mwm_lane import mwm_pkg::*; (
   input  logic         clock,
   input  load_type     ctrl,
   input  lane_cmd_type cmd,
   input  mag_type      max_mag,
   input  logic         scaled,
   input  reg_type      wheel_limit,
   output lane_out_type result
);

   // multiply stage
   logic [PROD_WIDTH-1:0] prod_ff;
   logic [PROD_WIDTH-1:0] prod_in;
   mag_type               mul_max_ff;
   logic                  mul_neg_ff;
   speed_type             mul_sat_ff;
   logic                  mul_scaled_ff;

   // divider stages
   mag_type   rem_ff    [DIV_STAGES];
   reg_type   qd_ff     [DIV_STAGES];
   mag_type   max_ff    [DIV_STAGES];
   logic      neg_ff    [DIV_STAGES];
   speed_type sat_ff    [DIV_STAGES];
   logic      scaled_ff [DIV_STAGES];

   lane_out_type          out_ff;
   lane_out_type          out_in;
   logic signed [REG_WIDTH:0] sq;

   assign prod_in = PROD_WIDTH'(cmd.mag) * PROD_WIDTH'(wheel_limit);

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_MUL]) begin
         prod_ff       <= prod_in;
         mul_max_ff    <= max_mag;
         mul_neg_ff    <= cmd.neg;
         mul_sat_ff    <= cmd.sat;
         mul_scaled_ff <= scaled;
      end
   end

   // upper product bits start the remainder, lower bits shift out as
   // quotient bits shift in
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      mag_type   rem_src;
      reg_type   qd_src;
      mag_type   max_src;
      logic      neg_src;
      speed_type sat_src;
      logic      scaled_src;
      mag_type   rem_in;
      reg_type   qd_in;
      logic [MAG_WIDTH:0] trial;
      logic               qbit;

      if (s == 0) begin : g_first
         assign rem_src    = prod_ff[PROD_WIDTH-1:REG_WIDTH];
         assign qd_src     = prod_ff[REG_WIDTH-1:0];
         assign max_src    = mul_max_ff;
         assign neg_src    = mul_neg_ff;
         assign sat_src    = mul_sat_ff;
         assign scaled_src = mul_scaled_ff;
      end else begin : g_next
         assign rem_src    = rem_ff[s-1];
         assign qd_src     = qd_ff[s-1];
         assign max_src    = max_ff[s-1];
         assign neg_src    = neg_ff[s-1];
         assign sat_src    = sat_ff[s-1];
         assign scaled_src = scaled_ff[s-1];
      end

      // restoring divide steps of this stage
      always_comb begin
         rem_in = rem_src;
         qd_in  = qd_src;
         trial  = '0;
         qbit   = 1'b0;
         for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
            if (s * DIV_STEPS_PER_STAGE + j < REG_WIDTH) begin
               trial = {rem_in, qd_in[REG_WIDTH-1]};
               qbit  = trial >= {1'b0, max_src};
               if (qbit) begin
                  rem_in = MAG_WIDTH'(trial - {1'b0, max_src});
               end else begin
                  rem_in = MAG_WIDTH'(trial);
               end
               qd_in = {qd_in[REG_WIDTH-2:0], qbit};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (ctrl.load[ST_DIV + s]) begin
            rem_ff[s]    <= rem_in;
            qd_ff[s]     <= qd_in;
            max_ff[s]    <= max_src;
            neg_ff[s]    <= neg_src;
            sat_ff[s]    <= sat_src;
            scaled_ff[s] <= scaled_src;
         end
      end
   end

   // sign the quotient, or pass the saturated sum
   always_comb begin
      sq = neg_ff[DIV_STAGES-1] ? -$signed({1'b0, qd_ff[DIV_STAGES-1]})
                                :  $signed({1'b0, qd_ff[DIV_STAGES-1]});
      out_in.scaled = scaled_ff[DIV_STAGES-1];
      out_in.speed  = scaled_ff[DIV_STAGES-1] ? SPEED_WIDTH'(sq) : sat_ff[DIV_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign result = out_ff;

endmodule

// ----- rtl/mecanum_wheel_mixer.sv -----
// mecanum wheel mixer top level: handshake control, configuration
// registers, front mix stages and four scaling lanes
// depends on mwm_pkg, mwm_req_if, mwm_rsp_if, mwm_csr, mwm_mix, mwm_lane
//
//   port      | dir | what it carries
//   ----------+-----+------------------------------------------------------
//   req_bus   | in  | valid/ready, speed_forward, speed_sideways, speed_rotation
//   rsp_bus   | out | valid/ready, wheel0..wheel3 speed, was_scaled
//   csr_*     | in  | write enable, register index, 15-bit write data
//
// one item per clock sustained while rsp ready stays high; ten register stages,
// the first loaded at the accepting edge, in this order:
// clamp, sum, max, multiply, five divider stages of three quotient bits
// each, output register.
// synchronous reset clears the stage valid bits and loads the register
// defaults; no clearing pass.
// each stage stalls only when it holds an item that cannot move on, so
// bubbles collapse and req ready stays high until all stages are full.
module mecanum_wheel_mixer import mwm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   mwm_req_if.sink                    req_bus,
   mwm_rsp_if.source                  rsp_bus,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  reg_type                    csr_write_data
);

   cfg_type                        cfg;
   load_type                       ctrl;
   lane_cmd_type [NUM_WHEELS-1:0]  cmd;
   mag_type                        max_mag;
   logic                           scaled;
   lane_out_type [NUM_WHEELS-1:0]  lane_res;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES:0]   ready;

   mwm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // stage ready chain and valid bits
   always_comb begin
      ready[NUM_STAGES] = rsp_bus.ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? req_bus.valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
      ctrl.load = ready[NUM_STAGES-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   mwm_mix u_mix (
      .clock          (clock),
      .ctrl           (ctrl),
      .cfg            (cfg),
      .speed_forward  (req_bus.speed_forward),
      .speed_sideways (req_bus.speed_sideways),
      .speed_rotation (req_bus.speed_rotation),
      .cmd            (cmd),
      .max_mag        (max_mag),
      .scaled         (scaled)
   );

   // one scaling lane per wheel
   for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_lane
      mwm_lane u_lane (
         .clock       (clock),
         .ctrl        (ctrl),
         .cmd         (cmd[i]),
         .max_mag     (max_mag),
         .scaled      (scaled),
         .wheel_limit (cfg.wheel_limit),
         .result      (lane_res[i])
      );
   end

   // channel outputs
   assign req_bus.ready        = ready[0];
   assign rsp_bus.valid        = valid_ff[ST_OUT];
   assign rsp_bus.wheel0_speed = lane_res[0].speed;
   assign rsp_bus.wheel1_speed = lane_res[1].speed;
   assign rsp_bus.wheel2_speed = lane_res[2].speed;
   assign rsp_bus.wheel3_speed = lane_res[3].speed;
   assign rsp_bus.was_scaled   = lane_res[0].scaled;

   // input is held off only when every stage holds an item
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> &valid_ff)
      else $error("req ready low with a bubble in the pipeline");

   // an item in the max stage moves into the multiply stage when it may
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_MAX] && ready[ST_MUL] |=> valid_ff[ST_MUL])
      else $error("item lost between max and multiply stages");

   // with the result taken and no new item, the first stage empties
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !req_bus.valid |=> !valid_ff[ST_CLAMP])
      else $error("item appeared in the clamp stage without a request");

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the mecanum wheel mixer: drives speed commands,
// writes the limit registers between phases and checks every wheel set
// depends on mwm_pkg, mwm_req_if, mwm_rsp_if and mecanum_wheel_mixer
`timescale 1ns / 1ps

module tb_top import mwm_pkg::*; ();

   localparam int     STALL_LIMIT   = 2000;
   localparam int     DRAIN_CYCLES  = 12;
   localparam int     RANDOM_PHASES = 8;
   localparam int     PHASE_ITEMS   = 200;
   localparam int     IDLE_PERCENT  = 34;
   localparam longint SPEED_MAX     = (longint'(1) <<< (SPEED_WIDTH - 1)) - 1;
   localparam longint SPEED_MIN     = -SPEED_MAX - 1;
   localparam int     REG_MAX       = (1 << REG_WIDTH) - 1;

   typedef struct {
      speed_type fwd;
      speed_type side;
      speed_type rot;
   } chassis_cmd_type;

   typedef struct {
      speed_type speed [NUM_WHEELS];
      logic      scaled;
   } wheel_set_type;

   logic    clock;
   logic    reset;
   logic    csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   reg_type csr_write_data;

   mwm_req_if req_bus ();
   mwm_rsp_if rsp_bus ();

   mecanum_wheel_mixer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // register copy kept in step with every write
   cfg_type         mixer_cfg;
   chassis_cmd_type cmd_queue [$];
   wheel_set_type   pending_wheel_sets [$];
   logic            cmd_taken;
   logic            steady;
   int              cmds_queued;
   int              cmds_accepted;
   int              results_seen;
   int              scaled_count;
   int              mismatches;
   int              settings_used;
   int              quiet_cycles;

   // clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // symmetric clamp of one command
   function automatic longint clamp_cmd(input speed_type v, input reg_type lim);
      longint s;
      longint l;
      s = v;
      l = lim;
      if (s > l) begin
         return l;
      end else if (s < -l) begin
         return -l;
      end
      return s;
   endfunction

   // inverse kinematics, peak search and proportional scaling
   function automatic wheel_set_type mix_wheels(input chassis_cmd_type cmd,
                                                input cfg_type c);
      wheel_set_type res;
      longint x, y, w, wl, peak, r;
      longint t [NUM_WHEELS];
      x = clamp_cmd(cmd.fwd, c.limit_forward);
      y = clamp_cmd(cmd.side, c.limit_sideways);
      w = clamp_cmd(cmd.rot, c.limit_rotation);
      wl = c.wheel_limit;
      t[0] = x - y + w;
      t[1] = -x - y + w;
      t[2] = -x + y + w;
      t[3] = x + y + w;
      peak = 0;
      for (int k = 0; k < NUM_WHEELS; k++) begin
         if ((t[k] < 0 ? -t[k] : t[k]) > peak) begin
            peak = t[k] < 0 ? -t[k] : t[k];
         end
      end
      res.scaled = peak > wl;
      for (int k = 0; k < NUM_WHEELS; k++) begin
         if (res.scaled) begin
            r = (t[k] * wl) / peak;
         end else if (t[k] > SPEED_MAX) begin
            r = SPEED_MAX;
         end else if (t[k] < SPEED_MIN) begin
            r = SPEED_MIN;
         end else begin
            r = t[k];
         end
         res.speed[k] = speed_type'(r);
      end
      return res;
   endfunction

   // random speed: full range, near the clamp limit, extremes or zero
   function automatic speed_type pick_speed(input reg_type lim);
      int span;
      int v;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            v = int'($urandom_range(0, 65535)) - 32768;
         end
         5, 6, 7: begin
            span = int'(lim) + 16;
            v = int'($urandom_range(0, 2 * span)) - span;
         end
         8: begin
            case ($urandom_range(4))
               0: v = int'(SPEED_MIN);
               1: v = int'(SPEED_MAX);
               2: v = -1;
               3: v = 1;
               default: v = 0;
            endcase
         end
         default: v = 0;
      endcase
      if (v > SPEED_MAX) v = int'(SPEED_MAX);
      if (v < SPEED_MIN) v = int'(SPEED_MIN);
      return speed_type'(v);
   endfunction

   // random clamp limit with weight on the ends of the range
   function automatic reg_type pick_limit(input bit nonzero);
      case ($urandom_range(5))
         0: return nonzero ? reg_type'(1) : reg_type'(0);
         1: return reg_type'(REG_MAX);
         2: return reg_type'($urandom_range(1, 255));
         default: return reg_type'($urandom_range(nonzero ? 1 : 0, REG_MAX));
      endcase
   endfunction

   task automatic queue_cmd(input int fwd, input int side, input int rot);
      chassis_cmd_type cmd;
      cmd.fwd  = speed_type'(fwd);
      cmd.side = speed_type'(side);
      cmd.rot  = speed_type'(rot);
      cmd_queue.push_back(cmd);
      cmds_queued++;
   endtask

   // write all four registers, one per falling edge
   task automatic write_regs(input reg_type fwd, input reg_type side,
                             input reg_type rot, input reg_type wheel);
      csr_index_type idx;
      reg_type       value;
      for (int k = 0; k < NUM_WHEELS; k++) begin
         idx = csr_index_type'(k);
         case (idx)
            CSR_LIMIT_FORWARD:  value = fwd;
            CSR_LIMIT_SIDEWAYS: value = side;
            CSR_LIMIT_ROTATION: value = rot;
            default:            value = wheel;
         endcase
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_index        <= idx;
         csr_write_data   <= value;
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
      mixer_cfg.limit_forward  = fwd;
      mixer_cfg.limit_sideways = side;
      mixer_cfg.limit_rotation = rot;
      mixer_cfg.wheel_limit    = wheel;
      settings_used++;
   endtask

   // hold off until every queued command has its wheel set back
   task automatic wait_drained();
      while (cmds_accepted != cmds_queued || pending_wheel_sets.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic flag_error(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", msg);
      end
   endtask

   // command driver, changes at the falling edge
   always @(negedge clock) begin : drive_commands
      chassis_cmd_type next_cmd;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || cmd_taken) begin
         if (cmd_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
            next_cmd = cmd_queue.pop_front();
            req_bus.valid          <= 1'b1;
            req_bus.speed_forward  <= next_cmd.fwd;
            req_bus.speed_sideways <= next_cmd.side;
            req_bus.speed_rotation <= next_cmd.rot;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result backpressure
   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // predict on each accepted command, check each accepted wheel set
   always @(posedge clock) begin : check_wheels
      wheel_set_type   want;
      chassis_cmd_type cmd;
      speed_type       got [NUM_WHEELS];
      if (reset) begin
         cmd_taken <= 1'b0;
      end else begin
         cmd_taken <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got[0] = rsp_bus.wheel0_speed;
            got[1] = rsp_bus.wheel1_speed;
            got[2] = rsp_bus.wheel2_speed;
            got[3] = rsp_bus.wheel3_speed;
            if (pending_wheel_sets.size() == 0) begin
               flag_error($sformatf("unexpected wheel set: %0d %0d %0d %0d scaled %0b",
                  got[0], got[1], got[2], got[3], rsp_bus.was_scaled));
            end else begin
               want = pending_wheel_sets.pop_front();
               if (want.scaled) scaled_count++;
               for (int k = 0; k < NUM_WHEELS; k++) begin
                  if (got[k] !== want.speed[k]) begin
                     flag_error($sformatf("wheel set %0d, wheel%0d: expected %0d, got %0d",
                        results_seen, k, want.speed[k], got[k]));
                  end
               end
               if (rsp_bus.was_scaled !== want.scaled) begin
                  flag_error($sformatf("wheel set %0d, was_scaled: expected %0b, got %0b",
                     results_seen, want.scaled, rsp_bus.was_scaled));
               end
            end
            results_seen++;
         end
         if (req_bus.valid && req_bus.ready) begin
            cmd.fwd  = req_bus.speed_forward;
            cmd.side = req_bus.speed_sideways;
            cmd.rot  = req_bus.speed_rotation;
            pending_wheel_sets.push_back(mix_wheels(cmd, mixer_cfg));
            cmds_accepted++;
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("mecanum_wheel_mixer test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin
      reset                  = 1'b1;
      steady                 = 1'b0;
      csr_write_enable       = 1'b0;
      csr_index              = CSR_LIMIT_FORWARD;
      csr_write_data         = '0;
      req_bus.valid          = 1'b0;
      req_bus.speed_forward  = '0;
      req_bus.speed_sideways = '0;
      req_bus.speed_rotation = '0;
      rsp_bus.ready          = 1'b0;
      cmds_queued            = 0;
      cmds_accepted          = 0;
      results_seen           = 0;
      scaled_count           = 0;
      mismatches             = 0;
      settings_used          = 1;
      quiet_cycles           = 0;
      mixer_cfg.limit_forward  = reg_type'(8000);
      mixer_cfg.limit_sideways = reg_type'(8000);
      mixer_cfg.limit_rotation = reg_type'(8000);
      mixer_cfg.wheel_limit    = reg_type'(3500);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset limits: single axes, clamping, peak exactly at and just past the limit
      queue_cmd(0, 0, 0);
      queue_cmd(100, 0, 0);
      queue_cmd(0, -200, 0);
      queue_cmd(0, 0, 300);
      queue_cmd(1000, 1000, 1000);
      queue_cmd(32767, 32767, 32767);
      queue_cmd(-32768, -32768, -32768);
      queue_cmd(32767, -32768, 0);
      queue_cmd(3500, 0, 0);
      queue_cmd(3501, 0, 0);
      wait_drained();

      // widest limits: full-scale commands and the unscaled peak at full range
      write_regs(reg_type'(REG_MAX), reg_type'(REG_MAX), reg_type'(REG_MAX),
                 reg_type'(REG_MAX));
      queue_cmd(32767, 32767, 32767);
      queue_cmd(-32768, -32768, -32768);
      queue_cmd(-32768, 32767, -1);
      queue_cmd(32767, 0, 0);
      wait_drained();

      // zero clamp limits force every command to zero
      write_regs('0, '0, '0, reg_type'(1));
      queue_cmd(12345, -12345, 32767);
      queue_cmd(-32768, 1, -1);
      wait_drained();

      // zero wheel limit: nonzero set scales to zeros, zero set passes
      write_regs(reg_type'(1), reg_type'(2), reg_type'(3), '0);
      queue_cmd(5, 5, 5);
      queue_cmd(0, 0, 0);
      wait_drained();

      // random phases, each under its own register setting
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0) begin
            write_regs(reg_type'(REG_MAX), reg_type'(REG_MAX), reg_type'(REG_MAX),
                       reg_type'(REG_MAX));
         end else if (ph == 1) begin
            write_regs(pick_limit(0), pick_limit(0), pick_limit(0), reg_type'(1));
         end else begin
            write_regs(pick_limit(0), pick_limit(0), pick_limit(0), pick_limit(1));
         end
         steady = (ph == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            queue_cmd(int'(pick_speed(mixer_cfg.limit_forward)),
                      int'(pick_speed(mixer_cfg.limit_sideways)),
                      int'(pick_speed(mixer_cfg.limit_rotation)));
         end
         wait_drained();
         steady = 1'b0;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d commands under %0d register settings", cmds_accepted, settings_used);
      $display("%0d wheel sets scaled, %0d passed unscaled, %0d mismatches",
         scaled_count, results_seen - scaled_count, mismatches);
      if (mismatches == 0 && pending_wheel_sets.size() == 0) begin
         $display("mecanum_wheel_mixer test passed");
      end else begin
         $display("mecanum_wheel_mixer test failed");
      end
      $finish;
   end

endmodule
